// File: rtl/core/four_level_page_table_walker_unit_defines.svh
// Assertion macros for the page table walker RTL.
// Each file that uses them includes this header; no other dependencies.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define PTW_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent at one edge implies the consequent at the next edge.
`define PTW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PTW_ASSERT_ALWAYS(name, cond, msg)
`define PTW_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// File: rtl/core/ptw_pkg.sv
// Types, constants and helpers shared by the page table walker modules.
// No dependencies.
`default_nettype none

package ptw_pkg;

  localparam int ADDR_W    = 48;
  localparam int DESC_W    = 64;
  localparam int LEVEL_W   = 2;
  localparam int INDEX_W   = 9;
  localparam int OFFSET_W  = 12;

  localparam logic [LEVEL_W-1:0] LEVEL_FIRST = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LAST  = 2'd3;

  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_RESPONSE  = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // One result beat
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic              fault;
  } ptw_result_t;

  // Outcome of one accepted beat: result push plus next walk state
  typedef struct packed {
    logic               push;
    ptw_result_t        result;
    logic               walking;
    logic [LEVEL_W-1:0] level;
    logic [ADDR_W-1:0]  held;
  } ptw_step_t;

  // Table index for a level: bits 47:39, 38:30, 29:21, 20:12
  function automatic logic [INDEX_W-1:0] table_index(input logic [ADDR_W-1:0] addr,
                                                     input logic [LEVEL_W-1:0] level);
    logic [INDEX_W-1:0] idx;
    idx = addr[47:39];
    unique case (level)
      2'd0:    idx = addr[47:39];
      2'd1:    idx = addr[38:30];
      2'd2:    idx = addr[29:21];
      default: idx = addr[20:12];
    endcase
    return idx;
  endfunction

  // Descriptor read address: table base with index scaled by 8 bytes
  function automatic logic [ADDR_W-1:0] desc_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [INDEX_W-1:0] idx);
    return {base[ADDR_W-1:OFFSET_W], idx, 3'b000};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ptw_step.sv
// Next-state and result logic for one beat of the page table walker.
// Depends on ptw_pkg.
`default_nettype none

module ptw_step (
  input  wire logic                         command,
  input  wire logic [ptw_pkg::ADDR_W-1:0]   in_address,
  input  wire logic [ptw_pkg::DESC_W-1:0]   descriptor,
  input  wire logic [ptw_pkg::ADDR_W-1:0]   table_root,
  input  wire logic                         walking,
  input  wire logic [ptw_pkg::LEVEL_W-1:0]  walk_level,
  input  wire logic [ptw_pkg::ADDR_W-1:0]   held_address,
  output ptw_pkg::ptw_step_t                step
);

  logic [ptw_pkg::LEVEL_W-1:0] level_inc;
  logic [ptw_pkg::ADDR_W-1:0]  desc_base;

  assign level_inc = walk_level + ptw_pkg::LEVEL_W'(1);
  assign desc_base = descriptor[ptw_pkg::ADDR_W-1:0];

  always_comb begin
    // default: drop the beat, keep state
    step.push           = 1'b0;
    step.result.kind    = ptw_pkg::KIND_READ;
    step.result.address = '0;
    step.result.fault   = 1'b0;
    step.walking        = walking;
    step.level          = walk_level;
    step.held           = held_address;

    if (command == ptw_pkg::CMD_TRANSLATE) begin
      // start a walk unless one is already running
      if (!walking) begin
        step.push           = 1'b1;
        step.walking        = 1'b1;
        step.level          = ptw_pkg::LEVEL_FIRST;
        step.held           = in_address;
        step.result.address = ptw_pkg::desc_addr(table_root,
                                ptw_pkg::table_index(in_address, ptw_pkg::LEVEL_FIRST));
      end
    end else if (walking) begin
      step.push = 1'b1;
      if (!descriptor[0]) begin
        // invalid descriptor ends the walk with a fault
        step.walking      = 1'b0;
        step.level        = ptw_pkg::LEVEL_FIRST;
        step.result.kind  = ptw_pkg::KIND_DONE;
        step.result.fault = 1'b1;
      end else if (walk_level != ptw_pkg::LEVEL_LAST) begin
        step.level          = level_inc;
        step.result.address = ptw_pkg::desc_addr(desc_base,
                                ptw_pkg::table_index(held_address, level_inc));
      end else begin
        // leaf: page base plus page offset
        step.walking        = 1'b0;
        step.level          = ptw_pkg::LEVEL_FIRST;
        step.result.kind    = ptw_pkg::KIND_DONE;
        step.result.address = {desc_base[ptw_pkg::ADDR_W-1:ptw_pkg::OFFSET_W],
                               held_address[ptw_pkg::OFFSET_W-1:0]};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ptw_out_buf.sv
// Two-entry output buffer (output register plus skid register) for result beats.
// Depends on ptw_pkg.
`default_nettype none

module ptw_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  ptw_pkg::ptw_result_t      push_data,
  output logic                      push_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ptw_pkg::ptw_result_t      out_data
);

  logic                 skid_valid;
  ptw_pkg::ptw_result_t skid_data;
  logic                 out_free;

  assign push_ready = !skid_valid;
  assign out_free   = !out_valid || out_ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/four_level_page_table_walker_unit.sv
// Four-level 4 KB-granule page table walker: one beat in, at most one beat out.
// A result beat is registered in the output buffer before it is valid.
// Throughput: 1 beat in per cycle while skid is empty; buffer absorbs one stall.
// Reset clears table_root, the walk state and the output buffer.
// Depends on ptw_pkg, ptw_step, ptw_out_buf and the defines header.
`default_nettype none
`include "four_level_page_table_walker_unit_defines.svh"

module four_level_page_table_walker_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [ptw_pkg::ADDR_W-1:0]  cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        command,
  input  wire logic [ptw_pkg::ADDR_W-1:0]  in_address,
  input  wire logic [ptw_pkg::DESC_W-1:0]  descriptor,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             kind,
  output logic [ptw_pkg::ADDR_W-1:0]       out_address,
  output logic                             fault
);

  logic [ptw_pkg::ADDR_W-1:0]  table_root;
  logic                        walking;
  logic [ptw_pkg::LEVEL_W-1:0] walk_level;
  logic [ptw_pkg::ADDR_W-1:0]  held_address;

  logic                        in_beat;
  ptw_pkg::ptw_step_t          step;
  ptw_pkg::ptw_result_t        out_data;

  assign in_beat = in_valid && in_ready;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_root <= '0;
    end else if (cfg_we) begin
      table_root <= cfg_wdata;
    end
  end

  ptw_step u_step (
    .command      (command),
    .in_address   (in_address),
    .descriptor   (descriptor),
    .table_root   (table_root),
    .walking      (walking),
    .walk_level   (walk_level),
    .held_address (held_address),
    .step         (step)
  );

  // walk state, updated on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      walking      <= 1'b0;
      walk_level   <= ptw_pkg::LEVEL_FIRST;
      held_address <= '0;
    end else if (in_beat) begin
      walking      <= step.walking;
      walk_level   <= step.level;
      held_address <= step.held;
    end
  end

  ptw_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (in_beat && step.push),
    .push_data  (step.result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign kind        = out_data.kind;
  assign out_address = out_data.address;
  assign fault       = out_data.fault;

  // checks
  `PTW_ASSERT_ALWAYS(a_level_idle, walking || (walk_level == ptw_pkg::LEVEL_FIRST), "level set while idle")
  `PTW_ASSERT_ALWAYS(a_fault_shape, !(out_valid && fault) || (kind && (out_address == '0)), "bad fault beat")
  `PTW_ASSERT_ALWAYS(a_stall_only_full, in_ready || out_valid, "input stalled with empty output")
  `PTW_ASSERT_NEXT(a_busy_translate_drop, in_beat && (command == ptw_pkg::CMD_TRANSLATE) && walking, $stable(held_address) && walking, "translate not dropped while walking")
  `PTW_ASSERT_NEXT(a_idle_resp_drop, in_beat && (command == ptw_pkg::CMD_RESPONSE) && !walking && !out_valid, !out_valid, "response while idle produced a beat")

endmodule

`default_nettype wire
